### hdl/multiple_sieve_kth_smallest_set_defines.svh
// Assertion macros shared by the sieve set RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef MULTIPLE_SIEVE_KTH_SMALLEST_SET_DEFINES_SVH
`define MULTIPLE_SIEVE_KTH_SMALLEST_SET_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define MSKS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sieve set check failed");
// Next-cycle implication.
`define MSKS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sieve set check failed");
`else
`define MSKS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MSKS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hdl/msks_pkg.sv
// Package for the sieve set: widths, beat structs, controller command/status.
// Depends on nothing.
`default_nettype none

package msks_pkg;

   localparam int VALUE_BITS = 16;
   localparam int LEAF_COUNT = 2 ** VALUE_BITS;
   localparam int FIELD_W    = 16;
   localparam int CNT_W      = VALUE_BITS + 1;
   localparam int RANK_W     = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
   localparam int PAD_W      = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;

   typedef struct packed {
      logic [FIELD_W-1:0] divisor;
      logic [FIELD_W-1:0] rank;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] kth_value;
      logic               found;
   } rsp_type;

   // Commands from the controller, at most two set in one cycle.
   typedef struct packed {
      logic load;
      logic clr;
      logic start_mult;
      logic mark;
      logic next_mult;
      logic up;
      logic root_read;
      logic start_desc;
      logic desc;
      logic miss;
      logic emit;
   } cmd_type;

   // Status from the datapath.
   typedef struct packed {
      logic div_ok;
      logic mult_removed;
      logic mult_last;
      logic node_root;
      logic rank_ok;
      logic desc_last;
      logic clr_done;
      logic can_emit;
   } sts_type;

endpackage

`default_nettype wire

### hdl/msks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module msks_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/msks_datapath.sv
// Datapath of the sieve set: removed-bit map, removed-count tree, walk registers.
// Depends on msks_pkg, msks_ram and the assertion macro header.
`default_nettype none
`include "multiple_sieve_kth_smallest_set_defines.svh"

module msks_datapath import msks_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Registers
   logic [VALUE_BITS-1:0] div_ff, div_in;
   logic                  div_live_ff, div_live_in;
   logic [RANK_W-1:0]     rank_ff, rank_in;
   logic [VALUE_BITS-1:0] mult_ff, mult_in;
   logic [VALUE_BITS:0]   node_ff, node_in;
   logic [CNT_W-1:0]      span_ff, span_in;
   logic                  edge_ff, edge_in;
   logic                  found_ff, found_in;
   logic [VALUE_BITS-1:0] clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Memory ports
   logic                  pres_we;
   logic [VALUE_BITS-1:0] pres_waddr;
   logic                  pres_wdata;
   logic [VALUE_BITS-1:0] pres_raddr;
   logic                  pres_rdata;
   logic                  cnt_we;
   logic [VALUE_BITS-1:0] cnt_waddr;
   logic [VALUE_BITS-1:0] cnt_wdata;
   logic [VALUE_BITS-1:0] cnt_raddr;
   logic [VALUE_BITS-1:0] cnt_rdata;

   // Combinational terms
   logic [PAD_W-1:0]      div_ext;
   logic                  req_div_live;
   logic [VALUE_BITS:0]   mult_sum;
   logic [VALUE_BITS:0]   leaf_parent;
   logic [VALUE_BITS:0]   node_up;
   logic [CNT_W-1:0]      total;
   logic                  leaf_step;
   logic [CNT_W-1:0]      used;
   logic [CNT_W-1:0]      left_cnt;
   logic                  go_right;
   logic [VALUE_BITS:0]   node_next;
   logic [VALUE_BITS-1:0] child_addr;

   // Bit set means the value has been removed; leaf 0 is absent by construction.
   msks_ram #(.WIDTH(1), .DEPTH(LEAF_COUNT)) u_pres_ram (
      .clock   (clock),
      .wr_en   (pres_we),
      .wr_addr (pres_waddr),
      .wr_data (pres_wdata),
      .rd_addr (pres_raddr),
      .rd_data (pres_rdata)
   );

   // Removed count per internal node; live count is span minus left edge minus this.
   msks_ram #(.WIDTH(VALUE_BITS), .DEPTH(LEAF_COUNT)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   always_comb begin
      div_ext      = PAD_W'(req_data.divisor);
      req_div_live = (div_ext != '0) && ((div_ext >> VALUE_BITS) == '0);
      mult_sum     = {1'b0, mult_ff} + {1'b0, div_ff};
      leaf_parent  = {2'b01, mult_ff[VALUE_BITS-1:1]};
      node_up      = node_ff >> 1;
      total        = CNT_W'(LEAF_COUNT - 1) - CNT_W'(cnt_rdata);
      leaf_step    = (span_ff == CNT_W'(1));
      used         = leaf_step ? CNT_W'(pres_rdata) : CNT_W'(cnt_rdata);
      left_cnt     = span_ff - CNT_W'(edge_ff) - used;
      go_right     = (rank_ff > RANK_W'(left_cnt));
      node_next    = {node_ff[VALUE_BITS-1:0], go_right};
      child_addr   = {node_next[VALUE_BITS-2:0], 1'b0};
   end

   // Memory addressing
   always_comb begin
      pres_we    = 1'b0;
      pres_waddr = mult_ff;
      pres_wdata = 1'b1;
      cnt_we     = 1'b0;
      cnt_waddr  = node_ff[VALUE_BITS-1:0];
      cnt_wdata  = cnt_rdata + VALUE_BITS'(1);
      pres_raddr = mult_ff;
      cnt_raddr  = node_ff[VALUE_BITS-1:0];

      if (cmd.clr) begin
         pres_we    = 1'b1;
         pres_waddr = clr_ff;
         pres_wdata = 1'b0;
         cnt_we     = 1'b1;
         cnt_waddr  = clr_ff;
         cnt_wdata  = '0;
      end
      if (cmd.mark) begin
         pres_we   = 1'b1;
         cnt_raddr = leaf_parent[VALUE_BITS-1:0];
      end
      if (cmd.up) begin
         cnt_we    = 1'b1;
         cnt_raddr = node_up[VALUE_BITS-1:0];
      end
      if (cmd.load) begin
         pres_raddr = div_ext[VALUE_BITS-1:0];
      end
      if (cmd.start_mult) begin
         pres_raddr = div_ff;
      end
      if (cmd.next_mult) begin
         pres_raddr = mult_sum[VALUE_BITS-1:0];
      end
      if (cmd.root_read) begin
         cnt_raddr = VALUE_BITS'(1);
      end
      if (cmd.start_desc) begin
         pres_raddr = VALUE_BITS'(2);
         cnt_raddr  = VALUE_BITS'(2);
      end
      if (cmd.desc) begin
         pres_raddr = child_addr;
         cnt_raddr  = child_addr;
      end
   end

   // Register next values
   always_comb begin
      div_in       = div_ff;
      div_live_in  = div_live_ff;
      rank_in      = rank_ff;
      mult_in      = mult_ff;
      node_in      = node_ff;
      span_in      = span_ff;
      edge_in      = edge_ff;
      found_in     = found_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         div_in      = div_ext[VALUE_BITS-1:0];
         div_live_in = req_div_live;
         rank_in     = RANK_W'(req_data.rank);
      end
      if (cmd.clr) begin
         clr_in = clr_ff + VALUE_BITS'(1);
      end
      if (cmd.start_mult) begin
         mult_in = div_ff;
      end
      if (cmd.next_mult) begin
         mult_in = mult_sum[VALUE_BITS-1:0];
      end
      if (cmd.mark) begin
         node_in = leaf_parent;
      end
      if (cmd.up) begin
         node_in = node_up;
      end
      if (cmd.start_desc) begin
         node_in  = (VALUE_BITS + 1)'(1);
         edge_in  = 1'b1;
         span_in  = CNT_W'(LEAF_COUNT / 2);
         found_in = 1'b1;
      end
      if (cmd.desc) begin
         node_in = node_next;
         span_in = span_ff >> 1;
         edge_in = edge_ff & ~go_right;
         if (go_right) begin
            rank_in = rank_ff - RANK_W'(left_cnt);
         end
      end
      if (cmd.miss) begin
         found_in = 1'b0;
      end

      // Output register: drop the beat once taken, load a new one on emit.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.found     = found_ff;
         rsp_data_in.kth_value = found_ff ? FIELD_W'(node_ff[VALUE_BITS-1:0]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_ff      <= div_in;
      div_live_ff <= div_live_in;
      rank_ff     <= rank_in;
      mult_ff     <= mult_in;
      node_ff     <= node_in;
      span_ff     <= span_in;
      edge_ff     <= edge_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      sts.div_ok       = div_live_ff && !pres_rdata;
      sts.mult_removed = pres_rdata;
      sts.mult_last    = mult_sum[VALUE_BITS];
      sts.node_root    = (node_ff == (VALUE_BITS + 1)'(1));
      sts.rank_ok      = (rank_ff != '0) && (rank_ff <= RANK_W'(total));
      sts.desc_last    = leaf_step;
      sts.clr_done     = (clr_ff == '1);
      sts.can_emit     = !(rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MSKS_ASSERT_NOW(a_rank_live, clock, reset, cmd.desc, rank_ff != '0)
   `MSKS_ASSERT_NOW(a_edge_power, clock, reset, cmd.desc && edge_ff, $onehot(node_ff))
   `MSKS_ASSERT_NOW(a_mark_live, clock, reset, cmd.mark, (mult_ff != '0) && !pres_rdata)

endmodule

`default_nettype wire

### hdl/msks_ctrl.sv
// Controller of the sieve set: sequences clearing, sieving, ancestor updates and descent.
// Depends on msks_pkg and the assertion macro header.
`default_nettype none
`include "multiple_sieve_kth_smallest_set_defines.svh"

module msks_ctrl import msks_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DCHK  = 4'd2;
   localparam logic [3:0] S_MCHK  = 4'd3;
   localparam logic [3:0] S_UP    = 4'd4;
   localparam logic [3:0] S_QROOT = 4'd5;
   localparam logic [3:0] S_QCHK  = 4'd6;
   localparam logic [3:0] S_DESC  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            if (sts.div_ok) begin
               cmd.start_mult = 1'b1;
               state_in       = S_MCHK;
            end else begin
               state_in = S_QROOT;
            end
         end
         S_MCHK: begin
            if (!sts.mult_removed) begin
               cmd.mark = 1'b1;
               state_in = S_UP;
            end else begin
               cmd.next_mult = 1'b1;
               if (sts.mult_last) begin
                  state_in = S_QROOT;
               end
            end
         end
         S_UP: begin
            cmd.up = 1'b1;
            if (sts.node_root) begin
               cmd.next_mult = 1'b1;
               state_in      = sts.mult_last ? S_QROOT : S_MCHK;
            end
         end
         S_QROOT: begin
            cmd.root_read = 1'b1;
            state_in      = S_QCHK;
         end
         S_QCHK: begin
            if (sts.rank_ok) begin
               cmd.start_desc = 1'b1;
               state_in       = S_DESC;
            end else begin
               cmd.miss = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DESC: begin
            cmd.desc = 1'b1;
            if (sts.desc_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.can_emit) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   `MSKS_ASSERT_NEXT(a_clear_once, clock, reset, state_ff != S_CLEAR, state_ff != S_CLEAR)
   `MSKS_ASSERT_NOW(a_emit_free, clock, reset, cmd.emit, sts.can_emit)
   `MSKS_ASSERT_NEXT(a_load_check, clock, reset, cmd.load, state_ff == S_DCHK)

endmodule

`default_nettype wire

### hdl/multiple_sieve_kth_smallest_set.sv
// Top level of the sieve set: order-statistic set over 1..2^VALUE_BITS-1 with sieving.
// Depends on msks_pkg, msks_ctrl and msks_datapath.
//
//   channel | direction | beat      | handshake
//   --------+-----------+-----------+----------------------------
//   req_    | in        | req_type  | req_valid / req_stall
//   rsp_    | out       | rsp_type  | rsp_valid / rsp_stall
//
// One beat in gives one beat out. With no removal an item checks the divisor, reads
// the root count, and the rank descent reads one tree level per cycle from the count RAM.
// A sieve visits each multiple of the divisor and, for each value removed, runs the
// ancestor walk of the count RAM (one node read and written a cycle).
// After reset a clearing pass zeroes both RAMs; req_stall stays high meanwhile.
// The output register holds its beat under rsp_stall while the next item is taken in.
`default_nettype none

module multiple_sieve_kth_smallest_set import msks_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Commands down, status up: the only link between the two halves.
   cmd_type cmd;
   sts_type sts;

   // Sequence each item: check divisor, walk multiples, update ancestors, descend.
   msks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Hold the removed-bit map, the removed-count tree and the output register.
   msks_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
